>>> src/dtti_pkg.sv
package dtti_pkg;

   localparam logic [19:0] TIME_MAX = 20'hFFFFF;

   localparam logic [1:0] CSR_BSCALE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_BSCALE_SLOPE  = 2'd1;
   localparam logic [1:0] CSR_TIME_WINDOW   = 2'd2;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef enum logic [23:0] {
      ST_IDLE = 24'h000001,
      ST_DEN  = 24'h000002,
      ST_DEN2 = 24'h000004,
      ST_CHK  = 24'h000008,
      ST_C1   = 24'h000010,
      ST_C2   = 24'h000020,
      ST_C3   = 24'h000040,
      ST_C4   = 24'h000080,
      ST_C5   = 24'h000100,
      ST_C6   = 24'h000200,
      ST_C7   = 24'h000400,
      ST_M0   = 24'h000800,
      ST_M1   = 24'h001000,
      ST_M2   = 24'h002000,
      ST_M3   = 24'h004000,
      ST_M4   = 24'h008000,
      ST_L1   = 24'h010000,
      ST_L2   = 24'h020000,
      ST_L3   = 24'h040000,
      ST_L4   = 24'h080000,
      ST_DV0  = 24'h100000,
      ST_DV1  = 24'h200000,
      ST_DIV  = 24'h400000,
      ST_FIN  = 24'h800000
   } state_type;

endpackage

>>> src/drift_time_table_interpolator.sv
// A table load word is taken while idle and gives no result.
// An evaluate word runs through the cubic or linear states and finishes early
// when the divisor or the sum is non-positive or the quotient overflows; one shared
// 32x22 multiplier steps through the weights and products, then a 20-step restoring divider.
// A new word is taken only while idle, after the last result is loaded, so a result stall holds it.
// Reset (synchronous, active high) clears control and loads register defaults; table is undefined.
module drift_time_table_interpolator #(
   parameter int TABLE_LEN = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [6:0]  req_table_index,
   input  logic [19:0] req_table_entry,
   input  logic [14:0] req_drift_radius,
   input  logic [13:0] req_field_magnitude,
   input  logic [19:0] req_cluster_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_drift_time,
   output logic [20:0] rsp_arrival_time,
   output logic        rsp_out_of_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int AW = $clog2(TABLE_LEN);
   localparam logic [31:0] LIN_BASE = 32'((TABLE_LEN - 3) * 256);
   localparam logic [AW-1:0] ADDR_LO = AW'(TABLE_LEN - 3);
   localparam logic [AW-1:0] ADDR_HI = AW'(TABLE_LEN - 1);

   dtti_pkg::state_type state_ff, state_in;

   logic signed [15:0] offset_ff, slope_ff;
   logic [19:0] window_ff;

   logic [19:0] mem [TABLE_LEN];
   logic [AW-1:0] rd_addr;
   logic [19:0] rd_ff;

   logic [14:0] r_ff;
   logic [13:0] fld_ff;
   logic [19:0] ct_ff;
   logic [6:0]  base_ff;
   logic [8:0]  a_ff;
   logic        lin_ff;
   logic [15:0] off_ff;

   logic signed [31:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [53:0] mul_prod, p_ff, p3;
   logic signed [31:0] t_ff;
   logic signed [31:0] w_ff [4];
   logic [19:0] e_ff [4];
   logic signed [55:0] acc_ff;
   logic signed [34:0] den_ff;
   logic [56:0] rem_ff;
   logic [52:0] dsh_ff;
   logic [4:0]  cnt_ff;
   logic [19:0] q_ff;

   logic rsp_valid_ff;
   logic [19:0] drift_ff;
   logic [20:0] arrival_ff;
   logic oow_ff;

   logic [6:0] seg;
   logic [6:0] base_c;
   logic signed [10:0] as, bs, cs, ds;
   logic accept, out_free, ge;
   logic [8:0] tmin;
   logic [19:0] drift_c;
   logic [33:0] den_u;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign seg      = req_drift_radius[14:8];
   assign base_c   = (seg == 7'd0) ? 7'd0 : seg - 7'd1;

   assign as = $signed({2'b00, a_ff});
   assign bs = as - 11'sd256;
   assign cs = as - 11'sd512;
   assign ds = as - 11'sd768;

   assign den_u = den_ff[33:0];
   assign p3    = p_ff + (p_ff <<< 1);
   assign ge    = rem_ff >= 57'(dsh_ff);
   assign tmin  = 9'((16'(r_ff) + 16'd64) >> 7);
   assign drift_c = (q_ff < 20'(tmin)) ? 20'(tmin) : q_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         dtti_pkg::ST_DEN: begin
            mul_a = 32'(slope_ff);
            mul_b = $signed({8'd0, fld_ff});
         end
         dtti_pkg::ST_C1: begin
            mul_a = 32'(cs);
            mul_b = 22'(ds);
         end
         dtti_pkg::ST_C2: begin
            mul_a = 32'(bs);
            mul_b = p_ff[21:0];
         end
         dtti_pkg::ST_C3: begin
            mul_a = 32'(as);
            mul_b = t_ff[21:0];
         end
         dtti_pkg::ST_C4: begin
            mul_a = 32'(as);
            mul_b = 22'(bs);
         end
         dtti_pkg::ST_C5: begin
            mul_a = p_ff[31:0];
            mul_b = 22'(ds);
         end
         dtti_pkg::ST_C6: begin
            mul_a = t_ff;
            mul_b = 22'(cs);
         end
         dtti_pkg::ST_M0: begin
            mul_a = w_ff[0];
            mul_b = $signed({2'b00, e_ff[0]});
         end
         dtti_pkg::ST_M1: begin
            mul_a = w_ff[1];
            mul_b = $signed({2'b00, e_ff[1]});
         end
         dtti_pkg::ST_M2: begin
            mul_a = w_ff[2];
            mul_b = $signed({2'b00, e_ff[2]});
         end
         dtti_pkg::ST_M3: begin
            mul_a = w_ff[3];
            mul_b = $signed({2'b00, e_ff[3]});
         end
         dtti_pkg::ST_L3: begin
            mul_a = $signed({16'd0, off_ff});
            mul_b = $signed({2'b00, rd_ff}) - $signed({2'b00, e_ff[0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      rd_addr = ADDR_LO;
      case (state_ff)
         dtti_pkg::ST_C1: rd_addr = AW'({1'b0, base_ff});
         dtti_pkg::ST_C2: rd_addr = AW'({1'b0, base_ff} + 8'd1);
         dtti_pkg::ST_C3: rd_addr = AW'({1'b0, base_ff} + 8'd2);
         dtti_pkg::ST_C4: rd_addr = AW'({1'b0, base_ff} + 8'd3);
         dtti_pkg::ST_L2: rd_addr = ADDR_HI;
         default:         rd_addr = ADDR_LO;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtti_pkg::ST_IDLE:
            if (accept && req_mode == dtti_pkg::MODE_EVAL) state_in = dtti_pkg::ST_DEN;
         dtti_pkg::ST_DEN:  state_in = dtti_pkg::ST_DEN2;
         dtti_pkg::ST_DEN2: state_in = dtti_pkg::ST_CHK;
         dtti_pkg::ST_CHK: begin
            if (den_ff <= 0)  state_in = dtti_pkg::ST_FIN;
            else if (lin_ff)  state_in = dtti_pkg::ST_L1;
            else              state_in = dtti_pkg::ST_C1;
         end
         dtti_pkg::ST_C1: state_in = dtti_pkg::ST_C2;
         dtti_pkg::ST_C2: state_in = dtti_pkg::ST_C3;
         dtti_pkg::ST_C3: state_in = dtti_pkg::ST_C4;
         dtti_pkg::ST_C4: state_in = dtti_pkg::ST_C5;
         dtti_pkg::ST_C5: state_in = dtti_pkg::ST_C6;
         dtti_pkg::ST_C6: state_in = dtti_pkg::ST_C7;
         dtti_pkg::ST_C7: state_in = dtti_pkg::ST_M0;
         dtti_pkg::ST_M0: state_in = dtti_pkg::ST_M1;
         dtti_pkg::ST_M1: state_in = dtti_pkg::ST_M2;
         dtti_pkg::ST_M2: state_in = dtti_pkg::ST_M3;
         dtti_pkg::ST_M3: state_in = dtti_pkg::ST_M4;
         dtti_pkg::ST_M4: state_in = dtti_pkg::ST_DV0;
         dtti_pkg::ST_L1: state_in = dtti_pkg::ST_L2;
         dtti_pkg::ST_L2: state_in = dtti_pkg::ST_L3;
         dtti_pkg::ST_L3: state_in = dtti_pkg::ST_L4;
         dtti_pkg::ST_L4: state_in = dtti_pkg::ST_DV0;
         dtti_pkg::ST_DV0:
            state_in = (acc_ff <= 0) ? dtti_pkg::ST_FIN : dtti_pkg::ST_DV1;
         dtti_pkg::ST_DV1:
            state_in = (rem_ff >= 57'({den_u, 20'd0})) ? dtti_pkg::ST_FIN
                                                         : dtti_pkg::ST_DIV;
         dtti_pkg::ST_DIV:
            if (cnt_ff == 5'd0) state_in = dtti_pkg::ST_FIN;
         dtti_pkg::ST_FIN:
            if (out_free) state_in = dtti_pkg::ST_IDLE;
         default: state_in = dtti_pkg::ST_IDLE;
      endcase
   end

   // table
   always_ff @(posedge clock) begin
      if (accept && req_mode == dtti_pkg::MODE_LOAD && 32'(req_table_index) < TABLE_LEN) begin
         mem[AW'(req_table_index)] <= req_table_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   // control and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtti_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= 16'sd4096;
         slope_ff     <= 16'sd0;
         window_ff    <= 20'd16000;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               dtti_pkg::CSR_BSCALE_OFFSET: offset_ff <= $signed(csr_data[15:0]);
               dtti_pkg::CSR_BSCALE_SLOPE:  slope_ff  <= $signed(csr_data[15:0]);
               dtti_pkg::CSR_TIME_WINDOW:   window_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == dtti_pkg::ST_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      p_ff <= mul_prod;
      case (state_ff)
         dtti_pkg::ST_IDLE: begin
            r_ff    <= req_drift_radius;
            fld_ff  <= req_field_magnitude;
            ct_ff   <= req_cluster_time;
            base_ff <= base_c;
            a_ff    <= 9'(req_drift_radius - {base_c, 8'd0});
            lin_ff  <= 32'(seg) >= 32'(TABLE_LEN - 3);
            off_ff  <= 16'(32'(req_drift_radius) - LIN_BASE);
         end
         dtti_pkg::ST_DEN2: den_ff <= (35'(offset_ff) <<< 12) + 35'(p_ff);
         dtti_pkg::ST_CHK:  q_ff <= dtti_pkg::TIME_MAX;
         dtti_pkg::ST_C2: begin
            t_ff    <= p_ff[31:0];
            e_ff[0] <= rd_ff;
         end
         dtti_pkg::ST_C3: begin
            w_ff[0] <= -p_ff[31:0];
            e_ff[1] <= rd_ff;
         end
         dtti_pkg::ST_C4: begin
            w_ff[1] <= p3[31:0];
            e_ff[2] <= rd_ff;
         end
         dtti_pkg::ST_C5: begin
            t_ff    <= p_ff[31:0];
            e_ff[3] <= rd_ff;
         end
         dtti_pkg::ST_C6: w_ff[2] <= -p3[31:0];
         dtti_pkg::ST_C7: w_ff[3] <= p_ff[31:0];
         dtti_pkg::ST_M1: acc_ff <= 56'(p_ff);
         dtti_pkg::ST_M2: acc_ff <= acc_ff + 56'(p_ff);
         dtti_pkg::ST_M3: acc_ff <= acc_ff + 56'(p_ff);
         dtti_pkg::ST_M4: begin
            acc_ff <= acc_ff + 56'(p_ff);
            den_ff <= (den_ff <<< 2) + (den_ff <<< 1);
         end
         dtti_pkg::ST_L2: e_ff[0] <= rd_ff;
         dtti_pkg::ST_L4:
            acc_ff <= (56'($signed({1'b0, e_ff[0], 9'd0})) + 56'(p_ff)) <<< 15;
         dtti_pkg::ST_DV0: begin
            q_ff   <= 20'd0;
            rem_ff <= 57'(acc_ff) + 57'(den_u >> 1);
         end
         dtti_pkg::ST_DV1: begin
            // saturate when the quotient cannot fit
            q_ff   <= (rem_ff >= 57'({den_u, 20'd0})) ? dtti_pkg::TIME_MAX : 20'd0;
            dsh_ff <= {den_u, 19'd0};
            cnt_ff <= 5'd19;
         end
         dtti_pkg::ST_DIV: begin
            if (ge) rem_ff <= rem_ff - 57'(dsh_ff);
            q_ff   <= {q_ff[18:0], ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
         end
         dtti_pkg::ST_FIN:
            if (out_free) begin
               drift_ff   <= drift_c;
               arrival_ff <= 21'(ct_ff) + 21'(drift_c);
               oow_ff     <= (21'(ct_ff) + 21'(drift_c)) > 21'(window_ff);
            end
         default: ;
      endcase
   end

   assign req_ready         = state_ff == dtti_pkg::ST_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drift_time    = drift_ff;
   assign rsp_arrival_time  = arrival_ff;
   assign rsp_out_of_window = oow_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(drift_ff))
      else $error("result word changed while stalled");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == dtti_pkg::ST_DIV |-> rem_ff < {3'd0, dsh_ff, 1'b0})
      else $error("divider remainder out of range");

   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == dtti_pkg::ST_FIN && state_in == dtti_pkg::ST_IDLE |=> rsp_valid_ff)
      else $error("result not loaded on finish");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != dtti_pkg::ST_IDLE |-> !req_ready)
      else $error("input taken while busy");

endmodule

>>> dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL_LEN    = 128;
   localparam int DRAIN_WAIT = 80;

   typedef struct packed {
      logic [19:0] drift;
      logic [20:0] arrival;
      logic        late;
   } arrival_type;

   typedef struct packed {
      logic        mode;
      logic [6:0]  idx;
      logic [19:0] entry;
      logic [14:0] radius;
      logic [13:0] field;
      logic [19:0] ctime;
      logic        typed;
      arrival_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = dtti_pkg::MODE_LOAD;
   logic [6:0]  req_table_index = '0;
   logic [19:0] req_table_entry = '0;
   logic [14:0] req_drift_radius = '0;
   logic [13:0] req_field_magnitude = '0;
   logic [19:0] req_cluster_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [19:0] rsp_drift_time;
   logic [20:0] rsp_arrival_time;
   logic        rsp_out_of_window;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   // predictor state
   logic [19:0]        drift_tbl [TBL_LEN];
   logic signed [15:0] scale_off;
   logic signed [15:0] scale_slope;
   logic [19:0]        window;

   arrival_type arrival_q [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   drift_time_table_interpolator dut (.*);

   always #10 clock = ~clock;

   initial begin
      #50_000_000;
      $display("tb_top failed");
      $finish;
   end

   function automatic arrival_type predict_arrival(logic [14:0] radius, logic [13:0] field,
                                                   logic [19:0] ctime);
      longint r, seg, den_base, num, den, q, tmin, drift, arr, t0, t2, base, a, b, c, d;
      arrival_type res;
      r = radius;
      seg = r / 256;
      den_base = longint'(scale_off) * 4096 + longint'(scale_slope) * longint'(field);
      num = 0;
      den = 1;
      if (den_base <= 0) begin
         q = dtti_pkg::TIME_MAX;
      end else begin
         if (seg >= TBL_LEN - 3) begin
            t0 = drift_tbl[TBL_LEN-3];
            t2 = drift_tbl[TBL_LEN-1];
            num = (t0 * 512 + (r - (TBL_LEN - 3) * 256) * (t2 - t0)) * 32768;
            den = den_base;
         end else begin
            base = (seg < 1) ? 0 : seg - 1;
            a = r - base * 256;
            b = a - 256;
            c = a - 512;
            d = a - 768;
            num = -(b * c * d) * longint'(drift_tbl[base])
                + 3 * a * c * d * longint'(drift_tbl[base+1])
                - 3 * a * b * d * longint'(drift_tbl[base+2])
                + a * b * c * longint'(drift_tbl[base+3]);
            den = 6 * den_base;
         end
         if (num <= 0) begin
            q = 0;
         end else begin
            q = (num + den / 2) / den;
            if (q > dtti_pkg::TIME_MAX) q = dtti_pkg::TIME_MAX;
         end
      end
      tmin = (r + 64) / 128;
      drift = (q < tmin) ? tmin : q;
      arr = longint'(ctime) + drift;
      res.drift = drift[19:0];
      res.arrival = arr[20:0];
      res.late = (arr > longint'(window));
      return res;
   endfunction

   // one word on the request channel; typed rows bypass the predictor
   task automatic send_word(logic mode, logic [6:0] idx, logic [19:0] entry,
                            logic [14:0] radius, logic [13:0] field, logic [19:0] ctime,
                            logic typed = 1'b0, arrival_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_table_index <= idx;
      req_table_entry <= entry;
      req_drift_radius <= radius;
      req_field_magnitude <= field;
      req_cluster_time <= ctime;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == dtti_pkg::MODE_LOAD) drift_tbl[idx] = entry;
      else arrival_q.insert(arrival_q.size(),
                            typed ? want : predict_arrival(radius, field, ctime));
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dtti_pkg::CSR_BSCALE_OFFSET: scale_off = data[15:0];
         dtti_pkg::CSR_BSCALE_SLOPE:  scale_slope = data[15:0];
         dtti_pkg::CSR_TIME_WINDOW:   window = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (arrival_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic random_words(int count);
      logic [14:0] radius;
      for (int i = 0; i < count; i++) begin
         radius = ($urandom_range(9) == 0) ? 15'($urandom_range(32767, 31744))
                                           : 15'($urandom);
         if ($urandom_range(4) == 0)
            send_word(dtti_pkg::MODE_LOAD, 7'($urandom), 20'($urandom), 15'($urandom),
                      14'($urandom), 20'($urandom));
         else
            send_word(dtti_pkg::MODE_EVAL, 7'($urandom), 20'($urandom), radius,
                      14'($urandom), ($urandom_range(3) == 0) ? 20'($urandom_range(2000))
                                                               : 20'($urandom));
      end
   endtask

   // receiver: random stall plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      arrival_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (arrival_q.size() == 0) begin
            $error("unexpected word: drift_time %0d", rsp_drift_time);
            errors++;
         end else begin
            exp_word = arrival_q.pop_front();
            if (rsp_drift_time !== exp_word.drift) begin
               $error("drift_time exp %0d got %0d", exp_word.drift, rsp_drift_time);
               errors++;
            end
            if (rsp_arrival_time !== exp_word.arrival) begin
               $error("arrival_time exp %0d got %0d", exp_word.arrival, rsp_arrival_time);
               errors++;
            end
            if (rsp_out_of_window !== exp_word.late) begin
               $error("out_of_window exp %0d got %0d", exp_word.late, rsp_out_of_window);
               errors++;
            end
         end
      end
   end

   initial begin
      dir_row_type dir_rows [21];
      int phase_off [6];
      int phase_slope [6];
      int phase_win [6];
      dir_rows = '{
         '{dtti_pkg::MODE_LOAD, 7'd0, 20'd1000, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd1, 20'd2000, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd2, 20'd3000, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd3, 20'd4000, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd0, 14'd0, 20'd0, 1'b1,
           '{20'd1000, 21'd1000, 1'b0}},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd0, 14'h3FFF, 20'hFFFFF, 1'b1,
           '{20'd1000, 21'd1049575, 1'b1}},
         '{dtti_pkg::MODE_LOAD, 7'd0, 20'hFFFFF, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd0, 14'd0, 20'hFFFFF, 1'b1,
           '{20'hFFFFF, 21'd2097150, 1'b1}},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd128, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd255, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd10, 20'd0, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd11, 20'd0, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd12, 20'd0, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd13, 20'hFFFFF, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         // cubic goes negative here, so the radius floor takes over
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd2944, 14'd0, 20'd7, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd32767, 14'h3FFF, 20'd12345, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd32000, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd127, 20'hFFFFF, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_LOAD, 7'd125, 20'd0, 15'd0, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd32767, 14'd0, 20'd0, 1'b0, '0},
         '{dtti_pkg::MODE_EVAL, 7'd0, 20'd0, 15'd16384, 14'd8192, 20'd524288, 1'b0, '0}
      };
      // offset, slope, window per random phase; extremes included
      phase_off   = '{4096, 32767, -32768, 1, 2048, 4096};
      phase_slope = '{-2000, 32767, 32767, 0, -32768, 1500};
      phase_win   = '{16000, 20'hFFFFF, 0, 500000, 16000, 300000};

      scale_off = 16'sd4096;
      scale_slope = 16'sd0;
      window = 20'd16000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the whole table before any evaluate
      for (int k = 0; k < TBL_LEN; k++)
         send_word(dtti_pkg::MODE_LOAD, 7'(k), 20'($urandom), 15'($urandom), 14'($urandom),
                   20'($urandom));
      foreach (dir_rows[i])
         send_word(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].entry, dir_rows[i].radius,
                   dir_rows[i].field, dir_rows[i].ctime, dir_rows[i].typed,
                   dir_rows[i].want);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_csr(dtti_pkg::CSR_BSCALE_OFFSET, 20'(phase_off[p]));
         write_csr(dtti_pkg::CSR_BSCALE_SLOPE, 20'(phase_slope[p]));
         write_csr(dtti_pkg::CSR_TIME_WINDOW, 20'(phase_win[p]));
         send_idle_pct  = (p % 4 == 1 || p == 5) ? 79 : (p % 4 == 3) ? 20 : 0;
         recv_stall_pct = (p % 4 == 2) ? 79 : (p % 4 == 3) ? 20 : 0;
         if (p == 4) hold_request = 400;
         random_words(200);
         drain();
      end

      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
